>>> sv/utf8sd_pkg.sv
// Shared types and constants for the six-byte UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LIMIT  = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_SHORT  = 2'd3;

  localparam logic [7:0] LEAD_SIX     = 8'b11111100;
  localparam logic [7:0] LEAD_FIVE    = 8'b11111000;
  localparam logic [7:0] LEAD_FOUR    = 8'b11110000;
  localparam logic [7:0] LEAD_THREE   = 8'b11100000;
  localparam logic [7:0] BAD_LEAD_MIN = 8'b11111110;
  localparam logic [1:0] CONT_TAG     = 2'b10;

  typedef struct packed {
    logic [30:0] acc;
    logic [2:0]  rem;
    logic        bad;
    logic        halted;
    logic [15:0] emitted;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] code_point;
    logic [1:0]  status;
    logic [15:0] start_offset;
    logic        stream_end;
  } dec_result_t;

endpackage

>>> sv/utf8sd_step.sv
// Per-byte decode step: next stream state and optional result for one byte.
// Depends on utf8sd_pkg.
module utf8sd_step
  import utf8sd_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  dec_state_t             cur,
  input  logic [OFFSET_BITS-1:0] byte_index,
  input  logic [OFFSET_BITS-1:0] seq_start,
  input  logic [7:0]             in_byte,
  input  logic                   end_of_stream,
  input  logic [15:0]            max_code_points,
  output dec_state_t             nxt,
  output logic [OFFSET_BITS-1:0] byte_index_next,
  output logic [OFFSET_BITS-1:0] seq_start_next,
  output dec_result_t            res
);

  logic        fin;
  logic        have_cp;
  logic [1:0]  st;
  logic [30:0] cp;
  logic [30:0] acc_sh;
  logic        bad_n;
  logic [2:0]  rem_n;
  logic [15:0] cnt;
  logic [31:0] seq_wide;

  assign acc_sh = {cur.acc[24:0], in_byte[5:0]};
  assign bad_n  = cur.bad | (in_byte[7:6] != CONT_TAG);
  assign rem_n  = cur.rem - 3'd1;
  assign cnt    = cur.emitted + 16'd1;

  always_comb begin
    nxt             = cur;
    byte_index_next = byte_index + OFFSET_BITS'(1);
    seq_start_next  = seq_start;
    fin             = 1'b0;
    have_cp         = 1'b0;
    st              = ST_OK;
    cp              = '0;
    if (!cur.halted) begin
      if (cur.rem == 3'd0) begin
        seq_start_next = byte_index;
        if (!in_byte[7]) begin
          cp      = {23'd0, in_byte};
          have_cp = 1'b1;
          fin     = 1'b1;
        end else if (in_byte[7:6] == CONT_TAG || in_byte >= BAD_LEAD_MIN) begin
          st  = ST_FAILED;
          fin = 1'b1;
        end else begin
          nxt.bad = 1'b0;
          if (in_byte >= LEAD_SIX) begin
            nxt.acc = {30'd0, in_byte[0]};
            nxt.rem = 3'd5;
          end else if (in_byte >= LEAD_FIVE) begin
            nxt.acc = {29'd0, in_byte[1:0]};
            nxt.rem = 3'd4;
          end else if (in_byte >= LEAD_FOUR) begin
            nxt.acc = {28'd0, in_byte[2:0]};
            nxt.rem = 3'd3;
          end else if (in_byte >= LEAD_THREE) begin
            nxt.acc = {27'd0, in_byte[3:0]};
            nxt.rem = 3'd2;
          end else begin
            nxt.acc = {26'd0, in_byte[4:0]};
            nxt.rem = 3'd1;
          end
          if (end_of_stream) begin
            nxt.rem = 3'd0;
            st      = ST_SHORT;
            fin     = 1'b1;
          end
        end
      end else begin
        nxt.bad = bad_n;
        nxt.acc = acc_sh;
        nxt.rem = rem_n;
        if (rem_n == 3'd0) begin
          fin = 1'b1;
          if (bad_n) begin
            st = ST_FAILED;
          end else begin
            cp      = acc_sh;
            have_cp = 1'b1;
          end
        end else if (end_of_stream) begin
          st      = ST_SHORT;
          fin     = 1'b1;
          nxt.rem = 3'd0;
        end
      end
      if (have_cp) begin
        nxt.emitted = cnt;
        if (max_code_points != 16'd0 && cnt >= max_code_points) begin
          st = ST_LIMIT;
        end
      end
      if (fin && st != ST_OK) begin
        nxt.halted = 1'b1;
      end
    end
    if (end_of_stream) begin
      nxt             = '0;
      byte_index_next = '0;
    end
  end

  assign seq_wide = 32'(seq_start_next);

  always_comb begin
    res.valid        = fin;
    res.code_point   = cp;
    res.status       = st;
    res.start_offset = seq_wide[15:0];
    res.stream_end   = end_of_stream || (st != ST_OK);
  end

endmodule

>>> sv/utf8_six_byte_stream_decoder.sv
// Top level of the six-byte UTF-8 stream decoder: input register, decode step,
// result register. Depends on utf8sd_pkg and utf8sd_step.
//
// Input channel: in_valid / in_stall with in_byte and end_of_stream; one byte
// per beat. Output channel: out_valid / out_stall with code_point, status,
// start_offset and stream_end; zero or one result beat per input byte.
// max_code_points is written through cfg_valid / cfg_ready (always ready) and
// applies to the following bytes. The user must write it only while the block
// is idle; the block itself does not enforce this. Throughput: one byte per
// cycle unless out_stall holds a pending result; the state update (shift-and-OR
// of the accumulator) between the input and result registers is combinational.
// When out_stall holds a pending result, the pipeline freezes and in_stall
// rises once the input register is full; nothing is dropped.
// rst (synchronous) clears the stream state, the pipeline and the limit register.
// Bytes after a failure or the limit produce no result up to and including the
// end-of-stream byte, which then resets the stream state.
module utf8_six_byte_stream_decoder
  import utf8sd_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] code_point,
  output logic [1:0]  status,
  output logic [15:0] start_offset,
  output logic        stream_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_code_points
);

  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_eos;
  logic                   advance;
  logic [15:0]            max_reg;

  dec_state_t             state;
  dec_state_t             state_next;
  logic [OFFSET_BITS-1:0] byte_index;
  logic [OFFSET_BITS-1:0] byte_index_next;
  logic [OFFSET_BITS-1:0] seq_start;
  logic [OFFSET_BITS-1:0] seq_start_next;
  dec_result_t            step_res;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_reg <= max_code_points;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= in_byte;
      in_q_eos  <= end_of_stream;
    end
  end

  utf8sd_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .cur             (state),
    .byte_index      (byte_index),
    .seq_start       (seq_start),
    .in_byte         (in_q_byte),
    .end_of_stream   (in_q_eos),
    .max_code_points (max_reg),
    .nxt             (state_next),
    .byte_index_next (byte_index_next),
    .seq_start_next  (seq_start_next),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      byte_index <= '0;
      seq_start  <= '0;
    end else if (in_q_valid && advance) begin
      state      <= state_next;
      byte_index <= byte_index_next;
      seq_start  <= in_q_eos ? '0 : seq_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_valid && step_res.valid) begin
      code_point   <= step_res.code_point;
      status       <= step_res.status;
      start_offset <= step_res.start_offset;
      stream_end   <= step_res.stream_end;
    end
  end

endmodule
